// ===== rtl/tdlex_pkg.sv =====
// Shared types, codes and the character classifier of the lexer block.
// No dependencies; every other file of the block but tdlex_if uses it.
`default_nettype none

package tdlex_pkg;

  localparam int LEXEME_MAX_DEF  = 20;
  localparam int QUEUE_DEPTH_DEF = 2;
  // Width of lexeme lengths and store addresses: covers LEXEME_MAX up to 63.
  localparam int LEN_W = 6;

  typedef enum logic [3:0] {
    CL_LETTER = 4'd0,
    CL_DIGIT  = 4'd1,
    CL_PLUS   = 4'd2,
    CL_MINUS  = 4'd3,
    CL_LPAREN = 4'd4,
    CL_RPAREN = 4'd5,
    CL_COMMA  = 4'd6,
    CL_SEMI   = 4'd7,
    CL_COLON  = 4'd8,
    CL_EQUAL  = 4'd9,
    CL_END    = 4'd10,
    CL_SPACE  = 4'd11,
    CL_OTHER  = 4'd12
  } char_class_t;

  typedef enum logic [3:0] {
    ST_START = 4'b0001,
    ST_IDENT = 4'b0010,
    ST_CONST = 4'b0100,
    ST_COLON = 4'b1000
  } scan_state_t;

  typedef enum logic [2:0] {
    PH_LEX = 3'b001,
    PH_S0  = 3'b010,
    PH_S1  = 3'b100
  } phase_t;

  localparam logic [3:0] TK_ERROR  = 4'd0;
  localparam logic [3:0] TK_IDENT  = 4'd1;
  localparam logic [3:0] TK_CONST  = 4'd2;
  localparam logic [3:0] TK_PLUS   = 4'd3;
  localparam logic [3:0] TK_MINUS  = 4'd4;
  localparam logic [3:0] TK_LPAREN = 4'd5;
  localparam logic [3:0] TK_RPAREN = 4'd6;
  localparam logic [3:0] TK_COMMA  = 4'd7;
  localparam logic [3:0] TK_SEMI   = 4'd8;
  localparam logic [3:0] TK_ASSIGN = 4'd9;
  localparam logic [3:0] TK_END    = 4'd10;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_EQUAL = 8'h3D;

  // One plain (non-lexeme) result.
  typedef struct packed {
    logic       vld;
    logic [3:0] kind;
    logic [7:0] ch;
    logic       second;  // char_index 1 (second character of ":=")
    logic       has;
    logic       tend;
  } slot_t;

  // Work for the back end caused by one item: an optional lexeme run,
  // then up to two plain results.
  typedef struct packed {
    logic             flush;
    logic [3:0]       fkind;
    logic [LEN_W-1:0] flen;
    logic             ftrunc;
    slot_t            s0;
    slot_t            s1;
  } cmd_t;

  typedef struct packed {
    logic             en;
    logic [LEN_W-1:0] addr;
    logic [7:0]       data;
  } store_wr_t;

  function automatic char_class_t classify(logic [7:0] c, logic eot);
    char_class_t cl;
    cl = CL_OTHER;
    priority if (eot) begin
      cl = CL_END;
    end else if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) begin
      cl = CL_LETTER;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      cl = CL_DIGIT;
    end else begin
      unique case (c)
        8'h2B:   cl = CL_PLUS;
        8'h2D:   cl = CL_MINUS;
        8'h28:   cl = CL_LPAREN;
        8'h29:   cl = CL_RPAREN;
        8'h2C:   cl = CL_COMMA;
        8'h3B:   cl = CL_SEMI;
        CH_COLON: cl = CL_COLON;
        CH_EQUAL: cl = CL_EQUAL;
        8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D: cl = CL_SPACE;
        default: cl = CL_OTHER;
      endcase
    end
    return cl;
  endfunction

  function automatic logic [3:0] single_kind(char_class_t cl);
    logic [3:0] k;
    unique case (cl)
      CL_PLUS:   k = TK_PLUS;
      CL_MINUS:  k = TK_MINUS;
      CL_LPAREN: k = TK_LPAREN;
      CL_RPAREN: k = TK_RPAREN;
      CL_COMMA:  k = TK_COMMA;
      CL_SEMI:   k = TK_SEMI;
      default:   k = TK_ERROR;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tdlex_if.sv =====
// Valid/ready channels of the lexer: character items in, token result items out.
// No dependencies.
`default_nettype none

interface tdlex_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;
  modport source (output valid, char_code, end_of_text, input ready);
  modport sink   (input valid, char_code, end_of_text, output ready);
endinterface

interface tdlex_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] token_kind;
  logic [7:0] lexeme_char;
  logic [4:0] char_index;
  logic       has_char;
  logic       lexeme_truncated;
  logic       token_end;
  logic       last;
  modport source (output valid, token_kind, lexeme_char, char_index, has_char,
                  lexeme_truncated, token_end, last, input ready);
  modport sink   (input valid, token_kind, lexeme_char, char_index, has_char,
                  lexeme_truncated, token_end, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/tdlex_front.sv =====
// Front end: accepts characters, classifies them, steps the scanner automaton
// and writes lexeme characters. Depends on tdlex_pkg and tdlex_if.
`default_nettype none

module tdlex_front #(
  parameter int LEXEME_MAX = tdlex_pkg::LEXEME_MAX_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  tdlex_in_if.sink                  chars,
  output tdlex_pkg::cmd_t           q_data,
  output logic                      q_push,
  input  wire logic                 q_space,
  input  wire logic                 lex_done,
  output tdlex_pkg::store_wr_t      wr
);

  tdlex_pkg::scan_state_t          state, state_next;
  logic [tdlex_pkg::LEN_W-1:0]     len, len_next;
  logic                            ovf, ovf_next;
  logic                            busy, busy_next;
  logic                            pend, pend_next;
  logic [7:0]                      pend_ch;
  tdlex_pkg::char_class_t          col;
  tdlex_pkg::cmd_t                 cmd;
  tdlex_pkg::slot_t                r;
  logic                            acc;
  logic                            rescan;
  logic [7:0]                      c;

  assign c           = chars.char_code;
  assign col         = tdlex_pkg::classify(chars.char_code, chars.end_of_text);
  // Hold off while a lexeme run is still being read out, a char is pending or the queue is full.
  assign chars.ready = !busy && !pend && q_space;
  assign acc         = chars.valid && chars.ready;

  always_comb begin
    state_next = state;
    len_next   = len;
    ovf_next   = ovf;
    busy_next  = busy;
    pend_next  = pend;
    cmd        = '0;
    r          = '0;
    wr         = '0;
    rescan     = 1'b0;

    if (lex_done) busy_next = 1'b0;

    // Write the deferred first character once the previous run is read out.
    if (pend && !busy) begin
      wr.en     = 1'b1;
      wr.addr   = '0;
      wr.data   = pend_ch;
      pend_next = 1'b0;
    end

    if (acc) begin
      unique case (state)
        tdlex_pkg::ST_IDENT, tdlex_pkg::ST_CONST: begin
          if (col == tdlex_pkg::CL_DIGIT ||
              (state == tdlex_pkg::ST_IDENT && col == tdlex_pkg::CL_LETTER)) begin
            if (len < tdlex_pkg::LEN_W'(LEXEME_MAX)) begin
              wr.en    = 1'b1;
              wr.addr  = len;
              wr.data  = c;
              len_next = len + tdlex_pkg::LEN_W'(1);
            end else begin
              ovf_next = 1'b1;
            end
          end else begin
            cmd.flush  = 1'b1;
            cmd.fkind  = (state == tdlex_pkg::ST_IDENT) ? tdlex_pkg::TK_IDENT
                                                        : tdlex_pkg::TK_CONST;
            cmd.flen   = len;
            cmd.ftrunc = ovf;
            busy_next  = 1'b1;
            len_next   = '0;
            ovf_next   = 1'b0;
            state_next = tdlex_pkg::ST_START;
            rescan     = 1'b1;
          end
        end
        tdlex_pkg::ST_COLON: begin
          state_next = tdlex_pkg::ST_START;
          if (col == tdlex_pkg::CL_EQUAL) begin
            cmd.s0.vld    = 1'b1;
            cmd.s0.kind   = tdlex_pkg::TK_ASSIGN;
            cmd.s0.ch     = tdlex_pkg::CH_COLON;
            cmd.s0.has    = 1'b1;
            cmd.s1.vld    = 1'b1;
            cmd.s1.kind   = tdlex_pkg::TK_ASSIGN;
            cmd.s1.ch     = tdlex_pkg::CH_EQUAL;
            cmd.s1.second = 1'b1;
            cmd.s1.has    = 1'b1;
            cmd.s1.tend   = 1'b1;
          end else begin
            cmd.s0.vld  = 1'b1;
            cmd.s0.kind = tdlex_pkg::TK_ERROR;
            cmd.s0.tend = 1'b1;
            rescan      = 1'b1;
          end
        end
        tdlex_pkg::ST_START: rescan = 1'b1;
        default: begin
          state_next = tdlex_pkg::ST_START;
          rescan     = 1'b1;
        end
      endcase

      if (rescan) begin
        unique case (col)
          tdlex_pkg::CL_LETTER, tdlex_pkg::CL_DIGIT: begin
            state_next = (col == tdlex_pkg::CL_LETTER) ? tdlex_pkg::ST_IDENT
                                                       : tdlex_pkg::ST_CONST;
            len_next   = tdlex_pkg::LEN_W'(1);
            ovf_next   = 1'b0;
            if (cmd.flush) begin
              pend_next = 1'b1;
            end else begin
              wr.en   = 1'b1;
              wr.addr = '0;
              wr.data = c;
            end
          end
          tdlex_pkg::CL_PLUS, tdlex_pkg::CL_MINUS, tdlex_pkg::CL_LPAREN,
          tdlex_pkg::CL_RPAREN, tdlex_pkg::CL_COMMA, tdlex_pkg::CL_SEMI: begin
            r.vld  = 1'b1;
            r.kind = tdlex_pkg::single_kind(col);
            r.ch   = c;
            r.has  = 1'b1;
            r.tend = 1'b1;
          end
          tdlex_pkg::CL_COLON: state_next = tdlex_pkg::ST_COLON;
          tdlex_pkg::CL_END: begin
            r.vld  = 1'b1;
            r.kind = tdlex_pkg::TK_END;
            r.tend = 1'b1;
          end
          tdlex_pkg::CL_SPACE: ;
          default: begin
            r.vld  = 1'b1;
            r.kind = tdlex_pkg::TK_ERROR;
            r.tend = 1'b1;
          end
        endcase
      end

      if (r.vld) begin
        if (cmd.s0.vld) cmd.s1 = r;
        else            cmd.s0 = r;
      end
    end
  end

  assign q_data = cmd;
  assign q_push = acc && (cmd.flush || cmd.s0.vld);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tdlex_pkg::ST_START;
      len   <= '0;
      ovf   <= 1'b0;
      busy  <= 1'b0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      len   <= len_next;
      ovf   <= ovf_next;
      busy  <= busy_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) pend_ch <= c;
  end

endmodule

`default_nettype wire

// ===== rtl/tdlex_queue.sv =====
// Short command queue between the lexer front and back ends.
// Depends on tdlex_pkg.
`default_nettype none

module tdlex_queue #(
  parameter int DEPTH = tdlex_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire tdlex_pkg::cmd_t push_data,
  output logic                 space,
  input  wire logic            pop,
  output tdlex_pkg::cmd_t      pop_data,
  output logic                 avail
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tdlex_pkg::cmd_t   slots [DEPTH];
  logic [PW-1:0]     wp, rp;
  logic [CW-1:0]     cnt;

  assign space    = (cnt != CW'(DEPTH));
  assign avail    = (cnt != '0);
  assign pop_data = slots[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + PW'(1);
      if (pop)  rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + PW'(1);
      priority if (push && !pop) cnt <= cnt + CW'(1);
      else if (pop && !push)     cnt <= cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wp] <= push_data;
  end

endmodule

`default_nettype wire

// ===== rtl/tdlex_back.sv =====
// Back end: holds the lexeme store and plays out each queued command as
// result items through an output register. Depends on tdlex_pkg and tdlex_if.
`default_nettype none

module tdlex_back #(
  parameter int LEXEME_MAX = tdlex_pkg::LEXEME_MAX_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire tdlex_pkg::store_wr_t wr,
  input  wire logic                 q_avail,
  input  wire tdlex_pkg::cmd_t      q_data,
  output logic                      q_pop,
  output logic                      lex_done,
  tdlex_out_if.source               tokens
);

  localparam int AW = $clog2(LEXEME_MAX);

  logic [7:0]                   store [LEXEME_MAX];
  logic [7:0]                   rd_q;
  tdlex_pkg::cmd_t              cur;
  logic                         cur_vld;
  tdlex_pkg::phase_t            phase, phase_next;
  logic [tdlex_pkg::LEN_W-1:0]  idx, idx_next;
  logic                         adv;

  logic [3:0] res_kind;
  logic [7:0] res_ch;
  logic [4:0] res_idx;
  logic       res_has, res_trunc, res_tend, res_last, res_lex;

  logic       out_vld;
  logic [3:0] out_kind;
  logic [7:0] out_ch;
  logic [4:0] out_idx;
  logic       out_has, out_trunc, out_tend, out_last, out_lex;

  assign adv   = cur_vld && (!out_vld || tokens.ready);
  assign q_pop = q_avail && (!cur_vld || (adv && res_last));

  always_comb begin
    phase_next = phase;
    idx_next   = idx;
    res_kind   = tdlex_pkg::TK_ERROR;
    res_ch     = '0;
    res_idx    = '0;
    res_has    = 1'b0;
    res_trunc  = 1'b0;
    res_tend   = 1'b1;
    res_last   = 1'b1;
    res_lex    = 1'b0;
    lex_done   = 1'b0;
    unique case (phase)
      tdlex_pkg::PH_LEX: begin
        res_kind  = cur.fkind;
        res_idx   = idx[4:0];
        res_has   = 1'b1;
        res_trunc = cur.ftrunc;
        res_lex   = 1'b1;
        res_tend  = (idx == cur.flen - tdlex_pkg::LEN_W'(1));
        res_last  = res_tend && !cur.s0.vld;
        lex_done  = adv && res_tend;
        idx_next  = idx + tdlex_pkg::LEN_W'(1);
        if (res_tend) phase_next = tdlex_pkg::PH_S0;
      end
      tdlex_pkg::PH_S0: begin
        res_kind   = cur.s0.kind;
        res_ch     = cur.s0.ch;
        res_idx    = {4'b0000, cur.s0.second};
        res_has    = cur.s0.has;
        res_tend   = cur.s0.tend;
        res_last   = !cur.s1.vld;
        phase_next = tdlex_pkg::PH_S1;
      end
      tdlex_pkg::PH_S1: begin
        res_kind = cur.s1.kind;
        res_ch   = cur.s1.ch;
        res_idx  = {4'b0000, cur.s1.second};
        res_has  = cur.s1.has;
        res_tend = cur.s1.tend;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_vld <= 1'b0;
      phase   <= tdlex_pkg::PH_LEX;
      idx     <= '0;
      out_vld <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_vld <= 1'b1;
        phase   <= q_data.flush ? tdlex_pkg::PH_LEX : tdlex_pkg::PH_S0;
        idx     <= '0;
      end else if (adv) begin
        phase <= phase_next;
        idx   <= idx_next;
        if (res_last) cur_vld <= 1'b0;
      end
      if (adv)               out_vld <= 1'b1;
      else if (tokens.ready) out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_data;
    if (adv) begin
      out_kind  <= res_kind;
      out_ch    <= res_ch;
      out_idx   <= res_idx;
      out_has   <= res_has;
      out_trunc <= res_trunc;
      out_tend  <= res_tend;
      out_last  <= res_last;
      out_lex   <= res_lex;
    end
  end

  // Lexeme store: one write port from the front, one registered read port.
  always_ff @(posedge clk) begin
    if (wr.en) store[wr.addr[AW-1:0]] <= wr.data;
    if (adv && phase == tdlex_pkg::PH_LEX) rd_q <= store[idx[AW-1:0]];
  end

  assign tokens.valid            = out_vld;
  assign tokens.token_kind       = out_kind;
  assign tokens.lexeme_char      = out_lex ? rd_q : out_ch;
  assign tokens.char_index       = out_idx;
  assign tokens.has_char         = out_has;
  assign tokens.lexeme_truncated = out_trunc;
  assign tokens.token_end        = out_tend;
  assign tokens.last             = out_last;

endmodule

`default_nettype wire

// ===== rtl/table_driven_lexer_dfa_top.sv =====
// Top level of the table-driven lexer: front end, command queue, back end.
// Depends on tdlex_pkg, tdlex_if, tdlex_front, tdlex_queue and tdlex_back.
//
// Usage:
//   chars  - one item per input character (char_code) or end-of-text mark.
//   tokens - result items, one per lexeme character; error and end tokens
//            give one item with has_char low. token_end marks the final item
//            of a token, last the final item caused by one input item.
//   An item moves when valid and ready are both high at a rising clk edge.
// Flow:
//   The front takes one character per cycle while the queue has room.
//   A single-character token passes through the command queue, the current
//   command register and the output register before it reaches tokens. A
//   finished identifier or constant of N stored characters plays out as N
//   items at one item per cycle while tokens.ready is high; the front takes
//   no new character until the last of them is read, nor, when the ending
//   character starts a new lexeme, until that character is written.
// Reset (rst, synchronous): scanner back at the start state, queue and
//   output register empty. The lexeme store is not cleared; no clearing pass.
// Stall: when tokens.ready is low the output register holds its item, the
//   back end stops, the queue fills and then chars.ready drops.
`default_nettype none

module table_driven_lexer_dfa_top #(
  parameter int LEXEME_MAX  = tdlex_pkg::LEXEME_MAX_DEF,
  parameter int QUEUE_DEPTH = tdlex_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  tdlex_in_if.sink    chars,
  tdlex_out_if.source tokens
);

  tdlex_pkg::cmd_t       push_data, pop_data;
  tdlex_pkg::store_wr_t  wr;
  logic                  push, space, pop, avail;
  logic                  lex_done;

  // Classify and step the automaton; write lexeme characters into the store.
  tdlex_front #(.LEXEME_MAX(LEXEME_MAX)) u_front (
    .clk      (clk),
    .rst      (rst),
    .chars    (chars),
    .q_data   (push_data),
    .q_push   (push),
    .q_space  (space),
    .lex_done (lex_done),
    .wr       (wr)
  );

  // Decouple the two ends so each can stall on its own.
  tdlex_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .space     (space),
    .pop       (pop),
    .pop_data  (pop_data),
    .avail     (avail)
  );

  // Play out lexeme runs and plain results.
  tdlex_back #(.LEXEME_MAX(LEXEME_MAX)) u_back (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .q_avail  (avail),
    .q_data   (pop_data),
    .q_pop    (pop),
    .lex_done (lex_done),
    .tokens   (tokens)
  );

  // Items without a character are single-item tokens at index zero.
  a_nochar_single: assert property (@(posedge clk) disable iff (rst)
    (tokens.valid && !tokens.has_char) |-> (tokens.token_end && tokens.char_index == 5'd0))
    else $error("character-less item is not a complete token at index zero");

  // Identifier and constant items always carry a lexeme character.
  a_lexeme_has_char: assert property (@(posedge clk) disable iff (rst)
    (tokens.valid && (tokens.token_kind == tdlex_pkg::TK_IDENT ||
                      tokens.token_kind == tdlex_pkg::TK_CONST)) |-> tokens.has_char)
    else $error("lexeme item without character");

  // The front must never write the store while the last character of a run is read.
  a_store_quiet: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> !lex_done)
    else $error("lexeme store written while its last character is read");

endmodule

`default_nettype wire
